// File: src/rcsfp_pkg.sv
`default_nettype none

package rcsfp_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int POS_W       = 5;
  localparam int STORE_DEPTH = FRAME_BYTES / 2;
  localparam int ADDR_W      = 4;
  localparam int IDX_W       = 4;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0]       HDR_FIRST   = 8'h20;
  localparam logic [7:0]       HDR_SECOND  = 8'h40;
  localparam logic [15:0]      CK_START    = 16'hFF9F;
  localparam logic [15:0]      LIMIT_RESET = 16'd1000;
  localparam logic [POS_W-1:0] FIRST_POS   = POS_W'(2);
  localparam logic [POS_W-1:0] CK_END_POS  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // byte write into the frame store; bank 0 holds even positions, bank 1 odd
  typedef struct packed {
    logic              we;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } rcsfp_wr_t;

  // end-of-frame event toward the emitter
  typedef struct packed {
    logic        good;
    logic        bad;
    logic [15:0] count;
  } rcsfp_fin_t;

endpackage

`default_nettype wire

// File: src/rcsfp_store.sv
`default_nettype none

module rcsfp_store (
  input  wire logic                         clk,
  input  wire rcsfp_pkg::rcsfp_wr_t         wr,
  input  wire logic                         rd_en,
  input  wire logic [rcsfp_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                        rd_lo,
  output logic [7:0]                        rd_hi
);

  logic [7:0] lo_mem [rcsfp_pkg::STORE_DEPTH];
  logic [7:0] hi_mem [rcsfp_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we && !wr.bank) begin
      lo_mem[wr.addr] <= wr.data;
    end
    if (wr.we && wr.bank) begin
      hi_mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo <= lo_mem[rd_addr];
      rd_hi <= hi_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/rcsfp_frame.sv
`default_nettype none

module rcsfp_frame (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  kind,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  cfg_we,
  input  wire logic [15:0]           cfg_data,
  output rcsfp_pkg::rcsfp_wr_t       wr,
  output rcsfp_pkg::rcsfp_fin_t      fin
);

  logic [7:0]                    prev_r, prev_nxt;
  logic [rcsfp_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [15:0]                   ck_r, ck_nxt;
  logic [7:0]                    rxlo_r, rxlo_nxt;
  logic [15:0]                   cnt_r, cnt_nxt;
  logic [15:0]                   lim_r;
  logic [15:0]                   cnt_base;
  logic [15:0]                   cnt_inc;

  assign cnt_base = (cnt_r == 16'd0 || cnt_r > lim_r) ? 16'd1 : cnt_r;
  assign cnt_inc  = cnt_base + 16'd1;

  always_comb begin
    prev_nxt = prev_r;
    pos_nxt  = pos_r;
    ck_nxt   = ck_r;
    rxlo_nxt = rxlo_r;
    cnt_nxt  = cnt_r;
    wr       = '0;
    fin      = '0;
    if (accept) begin
      if (kind == rcsfp_pkg::KIND_CLEAR) begin
        cnt_nxt = 16'd0;
      end else begin
        prev_nxt = data_byte;
        if (data_byte == rcsfp_pkg::HDR_SECOND && prev_r == rcsfp_pkg::HDR_FIRST) begin
          pos_nxt = rcsfp_pkg::FIRST_POS;
          ck_nxt  = rcsfp_pkg::CK_START;
        end else if (pos_r >= rcsfp_pkg::FIRST_POS) begin
          wr.we   = 1'b1;
          wr.bank = pos_r[0];
          wr.addr = pos_r[rcsfp_pkg::POS_W-1:1];
          wr.data = data_byte;
          if (pos_r == rcsfp_pkg::LAST_POS) begin
            pos_nxt = '0;
            if (ck_r == {data_byte, rxlo_r}) begin
              cnt_nxt   = cnt_inc;
              fin.good  = 1'b1;
              fin.count = cnt_inc;
            end else begin
              fin.bad   = 1'b1;
              fin.count = cnt_r;
            end
          end else begin
            // low half of the received checksum word
            if (pos_r == rcsfp_pkg::CK_END_POS) begin
              rxlo_nxt = data_byte;
            end
            if (pos_r < rcsfp_pkg::CK_END_POS) begin
              ck_nxt = ck_r - {8'd0, data_byte};
            end
            pos_nxt = pos_r + 1'b1;
          end
        end else begin
          pos_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pos_r  <= '0;
      ck_r   <= rcsfp_pkg::CK_START;
      cnt_r  <= '0;
      lim_r  <= rcsfp_pkg::LIMIT_RESET;
    end else begin
      prev_r <= prev_nxt;
      pos_r  <= pos_nxt;
      ck_r   <= ck_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        lim_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rxlo_r <= rxlo_nxt;
  end

endmodule

`default_nettype wire

// File: src/rcsfp_emit.sv
`default_nettype none

module rcsfp_emit #(
  parameter int CHANNELS_DECODED = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rcsfp_pkg::rcsfp_fin_t        fin,
  output logic                              in_ready,
  output logic                              rd_en,
  output logic [rcsfp_pkg::ADDR_W-1:0]      rd_addr,
  input  wire logic [7:0]                   rd_lo,
  input  wire logic [7:0]                   rd_hi,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rcsfp_pkg::IDX_W-1:0]       out_idx,
  output logic [15:0]                       out_value,
  output logic                              out_last,
  output logic                              out_good,
  output logic [15:0]                       out_count
);

  localparam logic [rcsfp_pkg::IDX_W-1:0] CH_END  = rcsfp_pkg::IDX_W'(CHANNELS_DECODED);
  localparam logic [rcsfp_pkg::IDX_W-1:0] CH_LAST = rcsfp_pkg::IDX_W'(CHANNELS_DECODED - 1);

  logic                          busy_r, busy_nxt;
  logic                          err_r, err_nxt;
  logic [rcsfp_pkg::IDX_W-1:0]   iss_r, iss_nxt;
  logic                          rdv_r, rdv_nxt;
  logic [rcsfp_pkg::IDX_W-1:0]   rdi_r;
  logic [15:0]                   cnt_r;
  logic                          ov_r, ov_nxt;
  logic [rcsfp_pkg::IDX_W-1:0]   oidx_r;
  logic [15:0]                   oval_r;
  logic                          olast_r;
  logic                          ogood_r;
  logic [15:0]                   ocnt_r;
  logic                          out_free;
  logic                          load_err;
  logic                          load_ch;

  assign out_free = !ov_r || out_ready;
  assign load_err = err_r && out_free;
  assign load_ch  = rdv_r && out_free;
  // channel k sits at byte positions 2k+2 and 2k+3, word address k+1
  assign rd_en    = busy_r && (iss_r != CH_END) && (!rdv_r || load_ch);
  assign rd_addr  = iss_r + 1'b1;
  assign in_ready = !busy_r && !err_r;

  always_comb begin
    busy_nxt = busy_r;
    err_nxt  = err_r;
    iss_nxt  = iss_r;
    rdv_nxt  = rdv_r;
    ov_nxt   = ov_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (load_err || load_ch) begin
      ov_nxt = 1'b1;
    end
    if (load_err) begin
      err_nxt = 1'b0;
    end
    if (load_ch) begin
      rdv_nxt = 1'b0;
      if (rdi_r == CH_LAST) begin
        busy_nxt = 1'b0;
      end
    end
    if (rd_en) begin
      rdv_nxt = 1'b1;
      iss_nxt = iss_r + 1'b1;
    end
    if (fin.good) begin
      busy_nxt = 1'b1;
      iss_nxt  = '0;
    end
    if (fin.bad) begin
      err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      err_r  <= 1'b0;
      iss_r  <= '0;
      rdv_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      err_r  <= err_nxt;
      iss_r  <= iss_nxt;
      rdv_r  <= rdv_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdi_r <= iss_r;
    end
    if (fin.good || fin.bad) begin
      cnt_r <= fin.count;
    end
    if (load_err) begin
      oidx_r  <= '0;
      oval_r  <= '0;
      olast_r <= 1'b1;
      ogood_r <= 1'b0;
      ocnt_r  <= cnt_r;
    end else if (load_ch) begin
      oidx_r  <= rdi_r;
      oval_r  <= {rd_hi, rd_lo};
      olast_r <= (rdi_r == CH_LAST);
      ogood_r <= 1'b1;
      ocnt_r  <= cnt_r;
    end
  end

  assign out_valid = ov_r;
  assign out_idx   = oidx_r;
  assign out_value = oval_r;
  assign out_last  = olast_r;
  assign out_good  = ogood_r;
  assign out_count = ocnt_r;

endmodule

`default_nettype wire

// File: src/rc_servo_frame_parser_core.sv
// Result path: good frame -> busy, store read, output register; bad frame -> error word.
// Throughput: one word per cycle; in_tready drops only while a frame's results drain.
// With out_tready high a good frame stalls input over one store read per channel.
// Reset: synchronous, active low; position, previous byte and counter go to zero,
// checksum to its seed, limit to 1000. Frame store contents are not cleared.
`default_nettype none

module rc_servo_frame_parser_core #(
  parameter int CHANNELS_DECODED = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,  // [7:0] data_byte
  input  wire logic                                in_tuser,  // [0] kind
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [3:0] channel_index, [19:4] channel_value, [35:20] message_count,
  // [36] link_active, [39:37] zero
  output logic [rcsfp_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                     out_tlast,
  output logic                                     out_tuser, // [0] frame_good
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [15:0]                         cfg_data
);

  rcsfp_pkg::rcsfp_wr_t          wr;
  rcsfp_pkg::rcsfp_fin_t         fin;
  logic                          accept;
  logic                          rd_en;
  logic [rcsfp_pkg::ADDR_W-1:0]  rd_addr;
  logic [7:0]                    rd_lo;
  logic [7:0]                    rd_hi;
  logic [rcsfp_pkg::IDX_W-1:0]   out_idx;
  logic [15:0]                   out_value;
  logic [15:0]                   out_count;

  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  rcsfp_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .kind      (in_tuser),
    .data_byte (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .fin       (fin)
  );

  rcsfp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi)
  );

  rcsfp_emit #(
    .CHANNELS_DECODED (CHANNELS_DECODED)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin       (fin),
    .in_ready  (in_tready),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_lo     (rd_lo),
    .rd_hi     (rd_hi),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_idx   (out_idx),
    .out_value (out_value),
    .out_last  (out_tlast),
    .out_good  (out_tuser),
    .out_count (out_count)
  );

  assign out_tdata = {3'b000, (out_count != 16'd0), out_count, out_value, out_idx};

endmodule

`default_nettype wire

// File: src/rcsfp_checker.sv
`default_nettype none

module rcsfp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("result word changed under stall");

  // checksum error word: single, index 0, value 0
  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[19:0] == 20'd0)
    else $error("malformed checksum error word");

  a_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36] == (out_tdata[35:20] != 16'd0))
    else $error("link flag disagrees with count");

  // input stays blocked until a frame's last channel has been produced
  a_drain_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken during channel run");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind rc_servo_frame_parser_core rcsfp_checker u_rcsfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
